>>> rtl/sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the serial frame receiver
// Byte width, register indexes, event codes, receive phases and the
// classified item that travels from the front end to the frame engine.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int PHASE_W = 3;
  localparam int CFG_INDEX_W = 2;

  // Default depth of the queue between front end and frame engine
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HDR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WANTED_TYPE = 2'd2;

  // Frame length counts two header bytes, the length byte and the checksum
  localparam logic [BYTE_W-1:0] OVERHEAD_LEN = 8'd4;
  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;
  localparam logic [BYTE_W-1:0] SUM_START = 8'h00;

  // Event codes
  localparam logic [KIND_W-1:0] EV_NONE = 3'd0;
  localparam logic [KIND_W-1:0] EV_BYTE = 3'd1;
  localparam logic [KIND_W-1:0] EV_OK = 3'd2;
  localparam logic [KIND_W-1:0] EV_OTHER = 3'd3;
  localparam logic [KIND_W-1:0] EV_BADSUM = 3'd4;
  localparam logic [KIND_W-1:0] EV_BADLEN = 3'd5;

  // Receive phases
  localparam logic [PHASE_W-1:0] PH_HEAD1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEAD2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SUM = 3'd4;

  // One received byte with its classification
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_hdr1;
    logic              is_hdr2;
    logic              short_len;
  } sfr_item_t;

endpackage
`default_nettype wire

>>> rtl/serial_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_top: two-byte-header frame deframer
// Hunts for the header, checks the length and additive checksum, passes
// payload bytes through with their offset and reports each frame's outcome.
//
//   channel   dir  handshake            contents
//   s_axis    in   tvalid/tready        tdata[7:0] rx_byte
//   m_axis    out  tvalid/tready        tuser event_kind, tdata payload/offset/type
//   cfg       in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One result transaction per received byte, one byte per cycle sustained while
// the output is not stalled. Each byte is held in the queue, then in the engine's
// output register. The queue lets input keep flowing for QUEUE_DEPTH bytes while
// the output is stalled. Synchronous reset returns to the header hunt and zeroes
// all but the output data and queue slots. Configuration is always ready.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top #(
  parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_offset, [23:16] frame_type_seen
  output logic [23:0]                          m_axis_tdata,
  output logic [sfr_pkg::KIND_W-1:0]           m_axis_tuser,  // [2:0] event_kind
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]      cfg_data
);
  import sfr_pkg::*;

  sfr_item_t         in_item;
  sfr_item_t         head_item;
  logic [BYTE_W-1:0] wanted_type;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  logic              q_push;

  assign s_axis_tready = !q_full;
  assign q_push = s_axis_tvalid && s_axis_tready;

  sfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (s_axis_tdata),
    .item        (in_item),
    .wanted_type (wanted_type)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  sfr_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (q_not_empty),
    .item            (head_item),
    .item_pop        (q_pop),
    .wanted_type     (wanted_type),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .event_kind      (m_axis_tuser),
    .payload_byte    (m_axis_tdata[7:0]),
    .payload_offset  (m_axis_tdata[15:8]),
    .frame_type_seen (m_axis_tdata[23:16])
  );

  // Event codes stay within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= EV_BADLEN))
    else $error("undefined event code on output");

  // Only payload events carry a payload byte and offset
  a_payload_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != EV_BYTE)) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("payload fields set on a non-payload event");

  // Frame type is reported only on frame end events
  a_type_only_on_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_BYTE || m_axis_tuser == EV_NONE ||
     m_axis_tuser == EV_BADLEN)) |-> (m_axis_tdata[23:16] == 8'd0))
    else $error("frame type set outside a frame end event");

  // A byte waiting in the queue moves on once the output is free
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_not_empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("queued byte not taken by the engine");

endmodule
`default_nettype wire

>>> rtl/sfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_front: configuration registers and byte classifier
// Holds the header and type registers and tags each incoming byte with
// its header matches and the short-length flag before it is queued.
// ----------------------------------------------------------------------------
module sfr_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]      cfg_data,
  input  wire logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
  output sfr_pkg::sfr_item_t                   item,
  output logic [sfr_pkg::BYTE_W-1:0]           wanted_type
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] first_hdr;
  logic [BYTE_W-1:0] second_hdr;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_hdr <= '0;
      second_hdr <= '0;
      wanted_type <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_HDR:   first_hdr <= cfg_data;
        REG_SECOND_HDR:  second_hdr <= cfg_data;
        REG_WANTED_TYPE: wanted_type <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the byte
  always_comb begin
    item.data = rx_byte;
    item.is_hdr1 = (rx_byte == first_hdr);
    item.is_hdr2 = (rx_byte == second_hdr);
    item.short_len = (rx_byte < MIN_FRAME_LEN);
  end

endmodule
`default_nettype wire

>>> rtl/sfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_queue: small first-word-fall-through queue
// Decouples the classifier from the frame engine so either side can stall.
// ----------------------------------------------------------------------------
module sfr_queue #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sfr_pkg::sfr_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output sfr_pkg::sfr_item_t      head
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sfr_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/sfr_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_engine: frame engine
// Walks the header, length, payload and checksum phases one byte per
// transaction and registers the resulting event for the output stream.
// ----------------------------------------------------------------------------
module sfr_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire sfr_pkg::sfr_item_t         item,
  output logic                            item_pop,
  input  wire logic [sfr_pkg::BYTE_W-1:0] wanted_type,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sfr_pkg::KIND_W-1:0]      event_kind,
  output logic [sfr_pkg::BYTE_W-1:0]      payload_byte,
  output logic [sfr_pkg::BYTE_W-1:0]      payload_offset,
  output logic [sfr_pkg::BYTE_W-1:0]      frame_type_seen
);
  import sfr_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0]  remaining, remaining_next;
  logic [BYTE_W-1:0]  index, index_next;
  logic [BYTE_W-1:0]  cur_type, cur_type_next;
  logic [KIND_W-1:0]  kind_next;
  logic [BYTE_W-1:0]  pbyte_next;
  logic [BYTE_W-1:0]  poff_next;
  logic [BYTE_W-1:0]  ftype_next;
  logic [BYTE_W-1:0]  remaining_dec;

  // Take the next byte whenever the output register is free or draining
  assign item_pop = item_valid && (!out_valid || out_ready);
  assign remaining_dec = remaining - 8'd1;

  // Phase logic
  always_comb begin
    phase_next = phase;
    running_sum_next = running_sum;
    remaining_next = remaining;
    index_next = index;
    cur_type_next = cur_type;
    kind_next = EV_NONE;
    pbyte_next = '0;
    poff_next = '0;
    ftype_next = '0;
    unique case (phase)
      PH_HEAD2: begin
        if (item.is_hdr2) begin
          running_sum_next = running_sum + item.data;
          phase_next = PH_LEN;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      PH_LEN: begin
        if (item.short_len) begin
          kind_next = EV_BADLEN;
          phase_next = PH_HEAD1;
        end else begin
          running_sum_next = running_sum + item.data;
          remaining_next = item.data - OVERHEAD_LEN;
          index_next = '0;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + item.data;
        if (index == '0) begin
          cur_type_next = item.data;
        end
        kind_next = EV_BYTE;
        pbyte_next = item.data;
        poff_next = index;
        index_next = index + 8'd1;
        remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        if (item.data != running_sum) begin
          kind_next = EV_BADSUM;
        end else if (cur_type == wanted_type) begin
          kind_next = EV_OK;
        end else begin
          kind_next = EV_OTHER;
        end
        ftype_next = cur_type;
        phase_next = PH_HEAD1;
      end
      default: begin
        // Hunt for the first header byte; unused codes land here too
        if (item.is_hdr1) begin
          running_sum_next = item.data;
          phase_next = PH_HEAD2;
        end else begin
          running_sum_next = SUM_START;
          phase_next = PH_HEAD1;
        end
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD1;
      running_sum <= SUM_START;
      remaining <= '0;
      index <= '0;
      cur_type <= '0;
    end else if (item_pop) begin
      phase <= phase_next;
      running_sum <= running_sum_next;
      remaining <= remaining_next;
      index <= index_next;
      cur_type <= cur_type_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (item_pop) begin
      event_kind <= kind_next;
      payload_byte <= pbyte_next;
      payload_offset <= poff_next;
      frame_type_seen <= ftype_next;
    end
  end

endmodule
`default_nettype wire
